[sv/bdq_pkg.sv]
// Shared types and constants for the bounded double-ended queue.
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int DEPTH_DEFAULT      = 1024;
    localparam int DATA_WIDTH_DEFAULT = 32;

    localparam int CAP_W   = 11;
    localparam int REQ_W   = 3;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_STATUS     = 3'd4
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

endpackage

[sv/bounded_double_ended_queue.sv]
// Top level of the bounded double-ended queue.
`timescale 1ns / 1ps
//
// Bounded deque of words held in a ring RAM with head/tail indices and a count.
// Request channel: an item is taken when start is high and busy is low.
//   req_type selects push front, push back, pop front, pop back or status;
//   item_value is the word for pushes.
// Result: done is high for exactly one cycle, registered in done_reg from the
//   ST_READ state; the result ports hold the outcome and the status after the
//   item. The receiver cannot stall, so nothing is held back.
// Each item passes through ST_READ, in which the RAM read data becomes the new
//   front or rear word after a pop; no new item is taken there. Pushes take
//   the same path so every item has the same latency.
// Front and rear words are cached in registers; a RAM read word is loaded into
//   them only when a pop leaves two or more entries.
// Configuration: cfg_valid/cfg_ready write the capacity register while idle.
//   A capacity above DEPTH acts as DEPTH, zero makes every push fail.
// Reset: deque empty, capacity 1024, RAM contents untouched (no RAM word is
//   used before it is written). No clearing pass is needed.

module bounded_double_ended_queue #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [bdq_pkg::REQ_W-1:0]   req_type,
    input  logic signed [bdq_pkg::VALUE_W-1:0] item_value,
    output logic                        done,
    output logic                        accepted,
    output logic signed [bdq_pkg::VALUE_W-1:0] front_value,
    output logic                        front_valid,
    output logic signed [bdq_pkg::VALUE_W-1:0] rear_value,
    output logic                        rear_valid,
    output logic                        is_empty,
    output logic                        is_full,
    output logic [bdq_pkg::COUNT_W-1:0] entry_count,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bdq_pkg::CAP_W-1:0]   cfg_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > bdq_pkg::CAP_W) ? CNT_W : bdq_pkg::CAP_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CMP_W-1:0] DEPTH_CMP = CMP_W'(DEPTH);

    bdq_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]          head_reg, head_next;
    logic [IDX_W-1:0]          tail_reg, tail_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [bdq_pkg::CAP_W-1:0] cap_reg;
    logic                      done_reg;
    logic                      ok_reg, ok_next;
    logic                      ld_front_reg, ld_front_next;
    logic                      ld_rear_reg, ld_rear_next;
    logic [DATA_WIDTH-1:0]     front_reg, rear_reg;

    logic                  take;
    logic                  full;
    logic [CMP_W-1:0]      cap_cmp, cap_eff, cnt_cmp, cnt_next_cmp;
    logic [DATA_WIDTH+31:0] word_ext;
    logic [DATA_WIDTH-1:0] word;
    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [DATA_WIDTH+31:0] front_ext, rear_ext;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_LAST) ? '0 : IDX_W'(i + 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_LAST : IDX_W'(i - 1'b1);
    endfunction

    assign take      = start && (state_reg == bdq_pkg::ST_IDLE);
    assign busy      = (state_reg != bdq_pkg::ST_IDLE);
    // capacity only changes between items
    assign cfg_ready = (state_reg == bdq_pkg::ST_IDLE) && !start;

    assign cap_cmp = CMP_W'(cap_reg);
    assign cap_eff = (cap_cmp > DEPTH_CMP) ? DEPTH_CMP : cap_cmp;
    assign cnt_cmp = CMP_W'(count_reg);
    assign full    = (cnt_cmp >= cap_eff);

    // word kept at DATA_WIDTH bits, zero above bit 31
    assign word_ext = {{DATA_WIDTH{1'b0}}, item_value};
    assign word     = word_ext[DATA_WIDTH-1:0];

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        ok_next       = 1'b1;
        ld_front_next = 1'b0;
        ld_rear_next  = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = head_reg;
        ram_re        = 1'b0;
        ram_raddr     = head_reg;
        unique case (req_type)
            bdq_pkg::REQ_PUSH_FRONT:
            begin
                if (full)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    head_next  = idx_dec(head_reg);
                    count_next = CNT_W'(count_reg + 1'b1);
                    ram_we     = take;
                    ram_waddr  = head_next;
                end
            end
            bdq_pkg::REQ_PUSH_BACK:
            begin
                if (full)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    tail_next  = idx_inc(tail_reg);
                    count_next = CNT_W'(count_reg + 1'b1);
                    ram_we     = take;
                    ram_waddr  = tail_reg;
                end
            end
            bdq_pkg::REQ_POP_FRONT:
            begin
                if (count_reg == '0)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    head_next     = idx_inc(head_reg);
                    count_next    = CNT_W'(count_reg - 1'b1);
                    ld_front_next = (count_reg >= CNT_W'(2'd3));
                    ram_re        = take;
                    ram_raddr     = head_next;
                end
            end
            bdq_pkg::REQ_POP_BACK:
            begin
                if (count_reg == '0)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    tail_next    = idx_dec(tail_reg);
                    count_next   = CNT_W'(count_reg - 1'b1);
                    ld_rear_next = (count_reg >= CNT_W'(2'd3));
                    ram_re       = take;
                    ram_raddr    = idx_dec(tail_next);
                end
            end
            default:
            begin
                // status only, unused codes included
                ok_next = 1'b1;
            end
        endcase
    end

    assign cnt_next_cmp = CMP_W'(count_next);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bdq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = bdq_pkg::ST_READ;
                end
            end
            bdq_pkg::ST_READ:
            begin
                state_next = bdq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bdq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bdq_pkg::ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            cap_reg      <= bdq_pkg::CAP_RESET;
            done_reg     <= 1'b0;
            ok_reg       <= 1'b0;
            ld_front_reg <= 1'b0;
            ld_rear_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == bdq_pkg::ST_READ);
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (take)
            begin
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                count_reg    <= count_next;
                ok_reg       <= ok_next;
                ld_front_reg <= ld_front_next;
                ld_rear_reg  <= ld_rear_next;
            end
            else if (state_reg == bdq_pkg::ST_READ)
            begin
                ld_front_reg <= 1'b0;
                ld_rear_reg  <= 1'b0;
            end
        end
    end

    // front/rear word cache; a pop leaving one entry copies the other end
    always_ff @(posedge clk)
    begin
        if (take && ok_next)
        begin
            if (req_type == bdq_pkg::REQ_PUSH_FRONT)
            begin
                front_reg <= word;
                if (count_reg == '0)
                begin
                    rear_reg <= word;
                end
            end
            else if (req_type == bdq_pkg::REQ_PUSH_BACK)
            begin
                rear_reg <= word;
                if (count_reg == '0)
                begin
                    front_reg <= word;
                end
            end
            else if (req_type == bdq_pkg::REQ_POP_FRONT && count_next == CNT_W'(1'b1))
            begin
                front_reg <= rear_reg;
            end
            else if (req_type == bdq_pkg::REQ_POP_BACK && count_next == CNT_W'(1'b1))
            begin
                rear_reg <= front_reg;
            end
        end
        else if (ld_front_reg && state_reg == bdq_pkg::ST_READ)
        begin
            front_reg <= ram_rdata;
        end
        else if (ld_rear_reg && state_reg == bdq_pkg::ST_READ)
        begin
            rear_reg <= ram_rdata;
        end
    end

    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (word),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign front_ext = {32'd0, front_reg};
    assign rear_ext  = {32'd0, rear_reg};

    assign done        = done_reg;
    assign accepted    = ok_reg;
    assign front_valid = (count_reg != '0);
    assign rear_valid  = (count_reg != '0);
    assign is_empty    = (count_reg == '0);
    assign is_full     = full;
    assign front_value = (count_reg != '0) ? front_ext[31:0] : '0;
    assign rear_value  = (count_reg != '0) ? rear_ext[31:0] : '0;
    assign entry_count = bdq_pkg::COUNT_W'(cnt_cmp);

    // item taken -> busy for exactly the read cycle
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> busy ##1 !busy)
        else $error("request slot not two cycles");

    // a result follows the read cycle
    a_done_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("missing result after read");

    // count never exceeds the ring depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_cmp <= DEPTH_CMP)
        else $error("occupancy beyond depth");

    // a push never lands past the effective capacity
    a_push_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (take && ok_next && count_next > count_reg) |-> (cnt_next_cmp <= cap_eff))
        else $error("push beyond capacity");

endmodule

[sv/bdq_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
